[src/msr_pkg.sv]
package msr_pkg;

	// Fixed field widths
	localparam int PPR_W    = 16;
	localparam int RATE_W   = 20;
	localparam int GAIN_W   = 16;
	localparam int TARGET_W = 16;
	localparam int TICK_W   = 32;
	localparam int TOTAL_W  = 32;
	localparam int DUTY_W   = 8;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 2;

	// count * 60 grows by this many bits
	localparam int MUL60_W = 6;

	localparam int DUTY_MAX    = 255;
	localparam int SEC_PER_MIN = 60;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PPR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KP   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KFF  = 2'd3;

	// Register reset values
	localparam logic [PPR_W-1:0]         PPR_RST  = 16'd1;
	localparam logic [RATE_W-1:0]        RATE_RST = 20'd1000;
	localparam logic signed [GAIN_W-1:0] KP_RST   = 16'sd256;
	localparam logic signed [GAIN_W-1:0] KFF_RST  = 16'sd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD1,
		ST_PROD2,
		ST_DIV,
		ST_SAT,
		ST_ERR,
		ST_MULP,
		ST_APPLY,
		ST_OUT
	} msr_state_t;

	typedef struct packed {
		logic accept;
		logic prod1;
		logic prod2;
		logic div_step;
		logic sat;
		logic err;
		logic mulp;
		logic apply;
		logic load_out;
		logic sampled;
	} msr_cmd_t;

endpackage

[src/msr_ctrl.sv]
module msr_ctrl
	import msr_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     sample,
	input  logic     command,
	input  logic     out_stall,
	output logic     in_stall,
	output logic     out_valid,
	output msr_cmd_t cmd
);

	localparam int NUM_W = COUNT_WIDTH + MUL60_W + RATE_W;
	localparam int CNT_W = $clog2(NUM_W);

	msr_state_t state_q, state_d;
	logic sample_q, command_q;
	logic [CNT_W-1:0] iter_q;
	logic out_valid_q;
	logic accept, out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sample)
						state_d = ST_PROD1;
					else if (command)
						state_d = ST_ERR;
					else
						state_d = ST_OUT;
				end
			end
			ST_PROD1: state_d = ST_PROD2;
			ST_PROD2: state_d = ST_DIV;
			ST_DIV: begin
				if (iter_q == '0)
					state_d = ST_SAT;
			end
			ST_SAT:   state_d = command_q ? ST_ERR : ST_OUT;
			ST_ERR:   state_d = ST_MULP;
			ST_MULP:  state_d = ST_APPLY;
			ST_APPLY: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.sampled  = sample_q;
		case (state_q)
			ST_IDLE:  cmd.accept   = in_valid;
			ST_PROD1: cmd.prod1    = 1'b1;
			ST_PROD2: cmd.prod2    = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_SAT:   cmd.sat      = 1'b1;
			ST_ERR:   cmd.err      = 1'b1;
			ST_MULP:  cmd.mulp     = 1'b1;
			ST_APPLY: cmd.apply    = 1'b1;
			ST_OUT:   cmd.load_out = out_free;
			default:  cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sample_q    <= 1'b0;
			command_q   <= 1'b0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sample_q  <= sample;
				command_q <= command;
			end
			// one quotient bit per cycle, MSB first
			if (state_q == ST_PROD2)
				iter_q <= CNT_W'(NUM_W - 1);
			else if (state_q == ST_DIV)
				iter_q <= iter_q - 1'b1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[src/msr_datapath.sv]
module msr_datapath
	import msr_pkg::*;
#(
	parameter int COUNT_WIDTH    = 16,
	parameter int SPEED_WIDTH    = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msr_cmd_t                      cmd,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          pulse,
	input  logic signed [TARGET_W-1:0]    setpoint,
	output logic                          drive_a,
	output logic                          drive_b,
	output logic [DUTY_W-1:0]             duty,
	output logic signed [SPEED_WIDTH-1:0] measured_speed,
	output logic [TOTAL_W-1:0]            pulse_total,
	output logic                          speed_updated
);

	localparam int C60_W = COUNT_WIDTH + MUL60_W;
	localparam int NUM_W = C60_W + RATE_W;
	localparam int DEN_W = TICK_W + PPR_W;
	localparam int EW    = ((SPEED_WIDTH > TARGET_W) ? SPEED_WIDTH : TARGET_W) + 1;
	localparam int PROD_W = GAIN_W + EW;
	localparam int FF_W   = GAIN_W + TARGET_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [NUM_W-1:0] POS_MAX = NUM_W'((64'd1 << (SPEED_WIDTH - 1)) - 64'd1);
	localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(64'd1 << (SPEED_WIDTH - 1));
	localparam logic signed [SUM_W-1:0] DUTY_LIM = SUM_W'(DUTY_MAX);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [TICK_W-1:0]      TICK_MAX  = '1;

	// configuration
	logic [PPR_W-1:0]         ppr_q;
	logic [RATE_W-1:0]        rate_q;
	logic signed [GAIN_W-1:0] kp_q, kff_q;

	// block state
	logic [COUNT_WIDTH-1:0]        count_q;
	logic [TICK_W-1:0]             ticks_q;
	logic signed [SPEED_WIDTH-1:0] speed_q;
	logic [TOTAL_W-1:0]            total_q;
	logic                          dir_rev_q;
	logic                          line_a_q, line_b_q;
	logic [DUTY_W-1:0]             duty_q;
	logic signed [TARGET_W-1:0]    target_q;

	// working registers
	logic [C60_W-1:0]          c60_q;
	logic [DEN_W-1:0]          den_q;
	logic [NUM_W-1:0]          num_q;
	logic [DEN_W-1:0]          rem_q;
	logic signed [EW-1:0]      err_q;
	logic signed [FF_W-1:0]    ff_q;
	logic signed [PROD_W-1:0]  prod_q;

	logic [PPR_W-1:0]         ppr_eff;
	logic [DEN_W:0]           trial;
	logic                     q_bit;
	logic [NUM_W-1:0]         mag_lim;
	logic [SPEED_WIDTH-1:0]   mag_sw;
	logic signed [SUM_W-1:0]  sum, pwm, pwm_mag;

	assign ppr_eff = (ppr_q == '0) ? PPR_W'(1) : ppr_q;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign q_bit = (trial >= {1'b0, den_q});

	always_comb begin
		if (dir_rev_q)
			mag_lim = (num_q > NEG_MAX) ? NEG_MAX : num_q;
		else
			mag_lim = (num_q > POS_MAX) ? POS_MAX : num_q;
		mag_sw = mag_lim[SPEED_WIDTH-1:0];
	end

	always_comb begin
		sum     = SUM_W'(prod_q) + SUM_W'(ff_q);
		pwm     = sum >>> GAIN_FRAC_BITS;
		pwm_mag = (pwm < 0) ? -pwm : pwm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q     <= PPR_RST;
			rate_q    <= RATE_RST;
			kp_q      <= KP_RST;
			kff_q     <= KFF_RST;
			count_q   <= '0;
			ticks_q   <= '0;
			speed_q   <= '0;
			total_q   <= '0;
			dir_rev_q <= 1'b0;
			line_a_q  <= 1'b0;
			line_b_q  <= 1'b0;
			duty_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PPR:  ppr_q  <= cfg_data[PPR_W-1:0];
					REG_RATE: rate_q <= cfg_data[RATE_W-1:0];
					REG_KP:   kp_q   <= cfg_data[GAIN_W-1:0];
					REG_KFF:  kff_q  <= cfg_data[GAIN_W-1:0];
					default:  ;
				endcase
			end
			if (cmd.accept) begin
				if (pulse && count_q != COUNT_MAX)
					count_q <= count_q + 1'b1;
				if (ticks_q != TICK_MAX)
					ticks_q <= ticks_q + 1'b1;
			end
			if (cmd.sat) begin
				speed_q <= dir_rev_q ? -mag_sw : mag_sw;
				total_q <= total_q + TOTAL_W'(count_q);
				count_q <= '0;
				ticks_q <= '0;
			end
			if (cmd.apply) begin
				if (pwm == '0) begin
					// brake; direction is kept
					line_a_q <= 1'b0;
					line_b_q <= 1'b0;
					duty_q   <= '0;
				end else begin
					line_a_q  <= (pwm > 0);
					line_b_q  <= (pwm < 0);
					dir_rev_q <= (pwm < 0);
					duty_q    <= (pwm_mag > DUTY_LIM) ? DUTY_W'(DUTY_MAX)
						: pwm_mag[DUTY_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			target_q <= setpoint;
		if (cmd.prod1) begin
			// x60 as x64 - x4
			c60_q <= (C60_W'(count_q) << 6) - (C60_W'(count_q) << 2);
			den_q <= DEN_W'(ticks_q * ppr_eff);
		end
		if (cmd.prod2) begin
			num_q <= NUM_W'(c60_q * rate_q);
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], q_bit};
		end
		if (cmd.err) begin
			err_q <= EW'(target_q) - EW'(speed_q);
			ff_q  <= kff_q * target_q;
		end
		if (cmd.mulp)
			prod_q <= kp_q * err_q;
		if (cmd.load_out) begin
			drive_a        <= line_a_q;
			drive_b        <= line_b_q;
			duty           <= duty_q;
			measured_speed <= speed_q;
			pulse_total    <= total_q;
			speed_updated  <= cmd.sampled;
		end
	end

endmodule

[src/motor_speed_regulator_top.sv]
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+---------------------------------------------
// in       | in_valid  | in_stall  | pulse, sample, command, setpoint
// out      | out_valid | out_stall | drive_a, drive_b, duty, measured_speed,
//          |           |           | pulse_total, speed_updated
// cfg      | cfg_we    | -         | cfg_index, cfg_data
//
// One item at a time. A tick with a sample runs through the bit-serial
// restoring divider, one quotient bit per cycle; a command adds the error,
// multiply and apply steps, and a plain tick goes straight to the output.
// Reset is asynchronous, active low, and returns the configuration and block
// state registers to their defaults. A finished result waits in the output
// register; the next item is taken meanwhile and completes once it frees up.
module motor_speed_regulator_top
	import msr_pkg::*;
#(
	parameter int COUNT_WIDTH    = 16,
	parameter int SPEED_WIDTH    = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          pulse,
	input  logic                          sample,
	input  logic                          command,
	input  logic signed [TARGET_W-1:0]    setpoint,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          drive_a,
	output logic                          drive_b,
	output logic [DUTY_W-1:0]             duty,
	output logic signed [SPEED_WIDTH-1:0] measured_speed,
	output logic [TOTAL_W-1:0]            pulse_total,
	output logic                          speed_updated
);

	msr_cmd_t cmd;

	msr_ctrl #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sample   (sample),
		.command  (command),
		.out_stall(out_stall),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.cmd      (cmd)
	);

	msr_datapath #(
		.COUNT_WIDTH   (COUNT_WIDTH),
		.SPEED_WIDTH   (SPEED_WIDTH),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pulse         (pulse),
		.setpoint      (setpoint),
		.drive_a       (drive_a),
		.drive_b       (drive_b),
		.duty          (duty),
		.measured_speed(measured_speed),
		.pulse_total   (pulse_total),
		.speed_updated (speed_updated)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block took an item but did not go busy");

	a_lines_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_a && drive_b))
		else $error("both direction lines high");

	a_brake_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_a && !drive_b |-> duty == '0)
		else $error("nonzero duty while braking");

endmodule
